// File: rtl/core/vdt_pkg.sv
`timescale 1ns / 1ps
package vdt_pkg;

	// Vertex store and bucket table are powers of two in size.
	localparam int VTX_AW       = 16;
	localparam int BKT_AW       = 16;
	localparam int MAX_VERTICES = 2 ** VTX_AW;
	localparam int NUM_BUCKETS  = 2 ** BKT_AW;

	localparam int KEY_W   = 16;
	localparam int WORD_W  = 32;
	localparam int INDEX_W = 16;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ADDED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] pos_x;
		logic [WORD_W-1:0] pos_y;
		logic [WORD_W-1:0] pos_z;
		logic [WORD_W-1:0] norm_x;
		logic [WORD_W-1:0] norm_y;
		logic [WORD_W-1:0] norm_z;
		logic [WORD_W-1:0] tex_u;
		logic [WORD_W-1:0] tex_v;
	} vtx_words_t;

	typedef struct packed {
		logic              has_next;
		logic [VTX_AW-1:0] next;
		vtx_words_t        words;
	} vtx_entry_t;

	typedef struct packed {
		logic              used;
		logic [VTX_AW-1:0] first;
	} bkt_entry_t;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_BKT   = 4'b0100,
		S_WALK  = 4'b1000
	} state_t;

endpackage

// File: rtl/core/vdt_ram.sv
`timescale 1ns / 1ps
module vdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/vertex_dedup_table.sv
`timescale 1ns / 1ps
// Channel   Ports                                         Handshake
// request   bucket_key, pos_*_bits, norm_*_bits, tex_*    start, busy
// result    vertex_index, lookup_status                   done (one-cycle strobe)
//
// After reset the bucket table is swept clear, one entry a cycle, with busy high.
// A request then stays busy through a bucket read and one vertex-store read per
// chain entry visited; a miss on an empty bucket needs only the bucket read. The
// result strobes in the cycle after the decision, and a new request may be taken
// in that same cycle. The receiver cannot stall.
module vertex_dedup_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [vdt_pkg::KEY_W-1:0]   bucket_key,
	input  logic [vdt_pkg::WORD_W-1:0]  pos_x_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  pos_y_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  pos_z_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  norm_x_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  norm_y_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  norm_z_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  tex_u_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  tex_v_bits,
	output logic                        done,
	output logic [vdt_pkg::INDEX_W-1:0] vertex_index,
	output logic [vdt_pkg::STAT_W-1:0]  lookup_status
);

	localparam int VTX_AW = vdt_pkg::VTX_AW;
	localparam int BKT_AW = vdt_pkg::BKT_AW;

	vdt_pkg::state_t state_q;
	logic [BKT_AW-1:0]       clr_q;
	logic [VTX_AW:0]         count_q;
	logic [BKT_AW-1:0]       bucket_q;
	vdt_pkg::vtx_words_t     vertex_q;
	logic [VTX_AW-1:0]       head_q;
	logic                    done_q;
	logic [vdt_pkg::INDEX_W-1:0] vertex_index_q;
	logic [vdt_pkg::STAT_W-1:0]  lookup_status_q;
	// Index of the entry whose data is on the vertex store output now.
	logic [VTX_AW-1:0]       cur_q;

	vdt_pkg::bkt_entry_t bkt_rd, bkt_wd;
	vdt_pkg::vtx_entry_t vtx_rd, vtx_wd;
	logic                bkt_we, bkt_re, vtx_we, vtx_re;
	logic [BKT_AW-1:0]   bkt_waddr, bkt_raddr;
	logic [VTX_AW-1:0]   vtx_raddr;

	logic              accept;
	logic              match, hit, miss, full, ins_go;
	logic [31:0]       key_ext;
	logic [31:0]       hit_ext, new_ext;
	vdt_pkg::vtx_words_t in_words;

	assign accept  = start && !busy;
	assign busy    = (state_q != vdt_pkg::S_IDLE);
	assign key_ext = 32'(bucket_key);

	assign in_words = '{pos_x: pos_x_bits, pos_y: pos_y_bits, pos_z: pos_z_bits,
		norm_x: norm_x_bits, norm_y: norm_y_bits, norm_z: norm_z_bits,
		tex_u: tex_u_bits, tex_v: tex_v_bits};

	assign match  = (vtx_rd.words == vertex_q);
	assign hit    = (state_q == vdt_pkg::S_WALK) && match;
	assign miss   = ((state_q == vdt_pkg::S_BKT) && !bkt_rd.used) ||
		((state_q == vdt_pkg::S_WALK) && !match && !vtx_rd.has_next);
	assign full   = count_q[VTX_AW];
	assign ins_go = miss && !full;

	assign hit_ext = 32'(cur_q);
	assign new_ext = 32'(count_q[VTX_AW-1:0]);

	// Bucket table: clearing sweep, head lookup on request, head update on insert.
	always_comb begin
		bkt_re    = accept;
		bkt_raddr = key_ext[BKT_AW-1:0];
		bkt_we    = 1'b0;
		bkt_waddr = bucket_q;
		bkt_wd    = '{used: 1'b1, first: count_q[VTX_AW-1:0]};
		if (state_q == vdt_pkg::S_CLEAR) begin
			bkt_we    = 1'b1;
			bkt_waddr = clr_q;
			bkt_wd    = '{used: 1'b0, first: '0};
		end else if (ins_go) begin
			bkt_we = 1'b1;
		end
	end

	// Vertex store: walk the chain, write the new entry at the head.
	always_comb begin
		vtx_re    = 1'b0;
		vtx_raddr = bkt_rd.first;
		if ((state_q == vdt_pkg::S_BKT) && bkt_rd.used) begin
			vtx_re = 1'b1;
		end else if ((state_q == vdt_pkg::S_WALK) && !match && vtx_rd.has_next) begin
			vtx_re    = 1'b1;
			vtx_raddr = vtx_rd.next;
		end
		vtx_we = ins_go;
		vtx_wd = '{has_next: (state_q == vdt_pkg::S_WALK), next: head_q, words: vertex_q};
	end

	vdt_ram #(
		.WIDTH ($bits(vdt_pkg::bkt_entry_t)),
		.DEPTH (vdt_pkg::NUM_BUCKETS)
	) u_bkt_ram (
		.clk   (clk),
		.we    (bkt_we),
		.waddr (bkt_waddr),
		.wdata (bkt_wd),
		.re    (bkt_re),
		.raddr (bkt_raddr),
		.rdata (bkt_rd)
	);

	vdt_ram #(
		.WIDTH ($bits(vdt_pkg::vtx_entry_t)),
		.DEPTH (vdt_pkg::MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (vtx_we),
		.waddr (count_q[VTX_AW-1:0]),
		.wdata (vtx_wd),
		.re    (vtx_re),
		.raddr (vtx_raddr),
		.rdata (vtx_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdt_pkg::S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= hit || miss;
			if (ins_go) begin
				count_q <= count_q + 1'b1;
			end
			unique case (state_q)
				vdt_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BKT_AW'(vdt_pkg::NUM_BUCKETS - 1)) begin
						state_q <= vdt_pkg::S_IDLE;
					end
				end
				vdt_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= vdt_pkg::S_BKT;
					end
				end
				vdt_pkg::S_BKT: begin
					state_q <= bkt_rd.used ? vdt_pkg::S_WALK : vdt_pkg::S_IDLE;
				end
				vdt_pkg::S_WALK: begin
					if (hit || miss) begin
						state_q <= vdt_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= vdt_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Request payload and walk bookkeeping.
	always_ff @(posedge clk) begin
		if (accept) begin
			bucket_q <= key_ext[BKT_AW-1:0];
			vertex_q <= in_words;
		end
		if (state_q == vdt_pkg::S_BKT) begin
			head_q <= bkt_rd.first;
		end
		if (vtx_re) begin
			cur_q <= vtx_raddr;
		end
		if (hit) begin
			vertex_index_q  <= hit_ext[vdt_pkg::INDEX_W-1:0];
			lookup_status_q <= vdt_pkg::STAT_FOUND;
		end else if (ins_go) begin
			vertex_index_q  <= new_ext[vdt_pkg::INDEX_W-1:0];
			lookup_status_q <= vdt_pkg::STAT_ADDED;
		end else if (miss) begin
			vertex_index_q  <= '0;
			lookup_status_q <= vdt_pkg::STAT_FULL;
		end
	end

	assign done          = done_q;
	assign vertex_index  = vertex_index_q;
	assign lookup_status = lookup_status_q;

endmodule

// File: dv/vertex_dedup_table_checker.sv
`timescale 1ns / 1ps
module vertex_dedup_table_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [vdt_pkg::KEY_W-1:0]   bucket_key,
	input  logic [vdt_pkg::WORD_W-1:0]  pos_x_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  pos_y_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  pos_z_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  norm_x_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  norm_y_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  norm_z_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  tex_u_bits,
	input  logic [vdt_pkg::WORD_W-1:0]  tex_v_bits,
	input  logic                        done,
	input  logic [vdt_pkg::INDEX_W-1:0] vertex_index,
	input  logic [vdt_pkg::STAT_W-1:0]  lookup_status,
	output int                          failures,
	output int                          pending
);
	import vdt_pkg::*;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [STAT_W-1:0]  status;
	} lookup_result_t;

	bit                bucket_used [NUM_BUCKETS];
	logic [VTX_AW-1:0] bucket_head [NUM_BUCKETS];
	vtx_entry_t        vtx_store   [MAX_VERTICES];
	int unsigned       stored_count;
	lookup_result_t    results_due [$];

	// Walk the bucket chain; on a miss store the vertex at the head of the chain, unless the store is full.
	function automatic lookup_result_t lookup_or_insert(input logic [KEY_W-1:0] key,
			input vtx_words_t words);
		int unsigned    bkt;
		int unsigned    e;
		int unsigned    steps;
		lookup_result_t r;
		bkt = int'(key) % NUM_BUCKETS;
		if (bucket_used[bkt]) begin
			e = bucket_head[bkt];
			steps = 0;
			while (steps <= stored_count) begin
				if (vtx_store[e].words == words) begin
					r.index = INDEX_W'(e);
					r.status = STAT_FOUND;
					return r;
				end
				if (!vtx_store[e].has_next)
					break;
				e = vtx_store[e].next;
				steps++;
			end
		end
		if (stored_count >= MAX_VERTICES) begin
			r.index = '0;
			r.status = STAT_FULL;
			return r;
		end
		e = stored_count;
		vtx_store[e].words = words;
		vtx_store[e].has_next = bucket_used[bkt];
		vtx_store[e].next = bucket_used[bkt] ? bucket_head[bkt] : '0;
		bucket_head[bkt] = VTX_AW'(e);
		bucket_used[bkt] = 1'b1;
		stored_count = e + 1;
		r.index = INDEX_W'(e);
		r.status = STAT_ADDED;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input lookup_result_t want,
			input lookup_result_t got);
		if (failures < 10)
			$display("%0t: %s: expected index %0d status %0d, got index %0d status %0d",
				$realtime, what, want.index, want.status, got.index, got.status);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		lookup_result_t got;
		if (!arst_n) begin
			foreach (bucket_used[i])
				bucket_used[i] = 1'b0;
			stored_count = 0;
			results_due.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (done) begin
				got.index = vertex_index;
				got.status = lookup_status;
				if (results_due.size() == 0) begin
					want = '0;
					note_mismatch("result with no request outstanding", want, got);
				end else begin
					want = results_due.pop_front();
					if (want.index !== got.index || want.status !== got.status)
						note_mismatch("lookup result mismatch", want, got);
				end
			end
			if (start && !busy)
				results_due.insert(results_due.size(), lookup_or_insert(bucket_key,
					{pos_x_bits, pos_y_bits, pos_z_bits, norm_x_bits, norm_y_bits,
					norm_z_bits, tex_u_bits, tex_v_bits}));
			pending = results_due.size();
		end
	end

endmodule

// File: dv/vertex_dedup_table_tb.sv
`timescale 1ns / 1ps
module vertex_dedup_table_tb;
	import vdt_pkg::*;

	localparam int STALL_LIMIT   = 4 * NUM_BUCKETS + 4096;
	localparam int RANDOM_ITEMS  = 500;
	localparam int DRAIN_CYCLES  = 16;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		vtx_words_t       w;
	} vertex_req_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [KEY_W-1:0]    bucket_key;
	logic [WORD_W-1:0]   pos_x_bits;
	logic [WORD_W-1:0]   pos_y_bits;
	logic [WORD_W-1:0]   pos_z_bits;
	logic [WORD_W-1:0]   norm_x_bits;
	logic [WORD_W-1:0]   norm_y_bits;
	logic [WORD_W-1:0]   norm_z_bits;
	logic [WORD_W-1:0]   tex_u_bits;
	logic [WORD_W-1:0]   tex_v_bits;
	logic                done;
	logic [INDEX_W-1:0]  vertex_index;
	logic [STAT_W-1:0]   lookup_status;
	int                  failures;
	int                  pending;
	int                  idle_cycles;
	vertex_req_t         sent_vertices [$];

	always #1 clk = ~clk;

	vertex_dedup_table DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.bucket_key    (bucket_key),
		.pos_x_bits    (pos_x_bits),
		.pos_y_bits    (pos_y_bits),
		.pos_z_bits    (pos_z_bits),
		.norm_x_bits   (norm_x_bits),
		.norm_y_bits   (norm_y_bits),
		.norm_z_bits   (norm_z_bits),
		.tex_u_bits    (tex_u_bits),
		.tex_v_bits    (tex_v_bits),
		.done          (done),
		.vertex_index  (vertex_index),
		.lookup_status (lookup_status)
	);

	vertex_dedup_table_checker u_checker (.*);

	function automatic vertex_req_t mk(input logic [KEY_W-1:0] key, input vtx_words_t w);
		vertex_req_t v;
		v.key = key;
		v.w = w;
		return v;
	endfunction

	function automatic vtx_words_t random_words();
		vtx_words_t w;
		w = '0;
		for (int i = 0; i < 8; i++)
			w = {w[WORD_W*7-1:0], WORD_W'($urandom)};
		return w;
	endfunction

	// Mostly repeats and near misses on a few busy buckets, so that chains grow long.
	function automatic vertex_req_t random_vertex();
		vertex_req_t v;
		int          pick;
		int          b;
		pick = $urandom_range(99);
		v = mk(KEY_W'($urandom), random_words());
		if (sent_vertices.size() == 0 || pick >= 90)
			return v;
		if (pick < 40) begin
			v = sent_vertices[$urandom_range(sent_vertices.size() - 1)];
		end else if (pick < 70) begin
			case ($urandom_range(3))
				0: v.key = '0;
				1: v.key = '1;
				2: v.key = KEY_W'(1);
				default: v.key = {1'b1, {(KEY_W-1){1'b0}}};
			endcase
		end else if (pick < 82) begin
			v = sent_vertices[$urandom_range(sent_vertices.size() - 1)];
			b = $urandom_range(WORD_W * 8 - 1);
			v.w[b] = ~v.w[b];
		end else begin
			v.w = sent_vertices[$urandom_range(sent_vertices.size() - 1)].w;
		end
		return v;
	endfunction

	task automatic issue(input vertex_req_t v, input int idle_pct, input bit keep);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < 24)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		bucket_key  <= v.key;
		pos_x_bits  <= v.w.pos_x;
		pos_y_bits  <= v.w.pos_y;
		pos_z_bits  <= v.w.pos_z;
		norm_x_bits <= v.w.norm_x;
		norm_y_bits <= v.w.norm_y;
		norm_z_bits <= v.w.norm_z;
		tex_u_bits  <= v.w.tex_u;
		tex_v_bits  <= v.w.tex_v;
		do @(posedge clk); while (busy);
		if (keep)
			sent_vertices.insert(sent_vertices.size(), v);
	endtask

	function automatic vertex_req_t fill_vertex(input int i);
		return mk(KEY_W'(i), {WORD_W'(i), 32'h6A09_E667, 32'hBB67_AE85, 32'h3C6E_F372,
			32'hA54F_F53A, 32'h510E_527F, 32'h9B05_688C, 32'h1F83_D9AB});
	endfunction

	// Abort when nothing moves for too long; the clearing sweep after reset is covered.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no request or result for %0d cycles", $realtime, idle_cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		vtx_words_t w;
		int         pct;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		bucket_key  <= '0;
		pos_x_bits  <= '0;
		pos_y_bits  <= '0;
		pos_z_bits  <= '0;
		norm_x_bits <= '0;
		norm_y_bits <= '0;
		norm_z_bits <= '0;
		tex_u_bits  <= '0;
		tex_v_bits  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Hits, misses down a chain, one-bit differences in each word, shared data.
		issue(mk('0, '0), 16, 1'b1);
		issue(mk('0, '0), 16, 1'b1);
		issue(mk('1, '1), 16, 1'b1);
		issue(mk('1, '1), 16, 1'b1);
		issue(mk('0, vtx_words_t'(1)), 16, 1'b1);
		issue(mk('0, '0), 16, 1'b1);
		issue(mk(KEY_W'(1), '0), 16, 1'b1);
		for (int j = 0; j < 8; j++) begin
			w = '0;
			w[WORD_W * (8 - j) - 1] = 1'b1;
			issue(mk('0, w), 16, 1'b1);
		end
		issue(mk('0, '0), 16, 1'b1);
		w = '0;
		w[WORD_W * 8 - 1] = 1'b1;
		issue(mk('0, w), 16, 1'b1);
		issue(mk('1, '0), 16, 1'b1);
		issue(mk('0, '1), 16, 1'b1);
		issue(mk({1'b1, {(KEY_W-1){1'b0}}}, '1), 16, 1'b1);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pct = (n < RANDOM_ITEMS / 3) ? 16 : (n < 2 * RANDOM_ITEMS / 3) ? 60 : 0;
			issue(random_vertex(), pct, 1'b1);
		end

		// Close with repeats, fresh vertices and fixed-pattern vertices on scattered keys.
		for (int n = 0; n < 24; n++) begin
			case (n % 3)
				0: issue(sent_vertices[$urandom_range(sent_vertices.size() - 1)], 16, 1'b0);
				1: issue(mk(KEY_W'($urandom), random_words()), 16, 1'b0);
				default: issue(fill_vertex($urandom_range(MAX_VERTICES - 1)), 16, 1'b0);
			endcase
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending != 0)
			$display("%0d lookup results never arrived", pending);
		if (failures == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
